@@ hdl/fbe_pkg.sv @@
package fbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int LAM_W     = 17;
    localparam int RAD_W     = 2 * DATA_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int PHI_NUM_W = 2 * DATA_W;
    localparam int PHI_DEN_W = DATA_W + 2;
    localparam int QUOT_W    = DATA_W + 1;
    localparam int PENQ_W    = 2 * DATA_W - 2 - FRAC_BITS;
    localparam int PHI_W     = DATA_W + 3;
    localparam int ACC_W     = 54;

    localparam logic [LAM_W-1:0] LAM_ONE = LAM_W'(1) << 16;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // Travels with the radicand through the square-root pipe
    typedef struct packed {
        logic [NUM_W-1:0]         num1;
        logic [NUM_W-1:0]         num2;
        logic                     neg1;
        logic                     neg2;
        logic                     kink;
        logic signed [DATA_W:0]   sum;
        logic [PHI_NUM_W-1:0]     ab2;
        logic                     phi_neg;
        logic [PENQ_W-1:0]        penq;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic                     pos_both;
    } fbe_sq_side_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        fbe_sq_side_t     side;
    } fbe_item_t;

    // Travels with the quotient through the divider pipe
    typedef struct packed {
        logic                     kink;
        logic                     sum_pos;
        logic                     phi_neg;
        logic signed [PHI_W-1:0]  phi_small;
        logic [PENQ_W-1:0]        penq;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic                     pos_both;
    } fbe_dv_side_t;

    typedef struct packed {
        logic              clip;
        logic [DATA_W-1:0] val;
    } fbe_sat_t;

    function automatic fbe_sat_t saturate(input logic signed [ACC_W-1:0] v);
        fbe_sat_t res;
        logic signed [ACC_W-1:0] lim;
        lim = v;
        res.clip = 1'b0;
        if (v > SAT_HI)
        begin
            lim = SAT_HI;
            res.clip = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            lim = SAT_LO;
            res.clip = 1'b1;
        end
        res.val = lim[DATA_W-1:0];
        return res;
    endfunction

endpackage

@@ hdl/fbe_sqrt.sv @@
module fbe_sqrt import fbe_pkg::*; #(
    parameter int RAD_BITS = 64,
    parameter int SIDE_W   = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_BITS-1:0]   in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_BITS/2-1:0] out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RT_W  = RAD_BITS / 2;
    localparam int REM_W = RT_W + 2;

    logic                v_reg    [0:RT_W];
    logic [RAD_BITS-1:0] rad_reg  [0:RT_W];
    logic [REM_W-1:0]    rem_reg  [0:RT_W];
    logic [RT_W-1:0]     root_reg [0:RT_W];
    logic [SIDE_W-1:0]   side_reg [0:RT_W];

    logic [REM_W-1:0] rem_sh   [0:RT_W-1];
    logic [REM_W-1:0] trial    [0:RT_W-1];
    logic             ge       [0:RT_W-1];
    logic [REM_W-1:0] rem_next [0:RT_W-1];

    // One root bit per stage: bring down two radicand bits, try 4q+1
    always_comb
    begin
        for (int k = 0; k < RT_W; k++)
        begin
            rem_sh[k]   = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_BITS-1 -: 2]};
            trial[k]    = {root_reg[k], 2'b01};
            ge[k]       = rem_sh[k] >= trial[k];
            rem_next[k] = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RT_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < RT_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int k = 0; k < RT_W; k++)
            begin
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= {root_reg[k][RT_W-2:0], ge[k]};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[RT_W];
    assign out_root  = root_reg[RT_W];
    assign out_side  = side_reg[RT_W];

endmodule

@@ hdl/fbe_div.sv @@
module fbe_div import fbe_pkg::*; #(
    parameter int N_W    = 48,
    parameter int D_W    = 32,
    parameter int Q_W    = 33,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [N_W-1:0]    in_num,
    input  logic [D_W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [0:Q_W];
    logic [D_W-1:0]    rem_reg  [0:Q_W];
    logic [Q_W-1:0]    lq_reg   [0:Q_W];
    logic [D_W-1:0]    den_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];

    logic [D_W:0]   rem_sh   [0:Q_W-1];
    logic           ge       [0:Q_W-1];
    logic [D_W-1:0] rem_next [0:Q_W-1];

    // Restoring step: numerator bits shift out of lq, quotient bits shift in
    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            rem_sh[k]   = {rem_reg[k], lq_reg[k][Q_W-1]};
            ge[k]       = rem_sh[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge[k] ? D_W'(rem_sh[k] - {1'b0, den_reg[k]})
                                : rem_sh[k][D_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < Q_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= D_W'(in_num >> Q_W);
            lq_reg[0]   <= in_num[Q_W-1:0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                lq_reg[k+1]   <= {lq_reg[k][Q_W-2:0], ge[k]};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign out_quot  = lq_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

@@ hdl/fbe_front.sv @@
module fbe_front import fbe_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] a_value,
    input  logic signed [DATA_W-1:0] b_value,
    input  logic signed [DATA_W-1:0] kink_gradient,
    output logic                     push,
    output fbe_item_t                push_item,
    input  logic                     full
);

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(~v + 1'b1) : DATA_W'(v);
    endfunction

    logic fe;
    logic v1_reg, v2_reg;

    logic signed [DATA_W-1:0] a1_reg, b1_reg;
    logic [DATA_W-1:0]        ma1_reg, mb1_reg, mg1_reg;
    logic                     gzneg1_reg, kink1_reg;

    logic signed [DATA_W-1:0] a2_reg, b2_reg;
    logic [DATA_W-1:0]        ma2_reg, mb2_reg, mg2_reg;
    logic                     gzneg2_reg, kink2_reg;
    logic [RAD_W-1:0]         sqx_reg, sqb_reg, ab_reg, pp_reg;

    logic [DATA_W-1:0] sel_x, pa1, pb1;

    assign fe       = !v2_reg || !full;
    assign in_ready = fe;
    assign push     = v2_reg && !full;

    // At the kink a is zero, so its square slot takes gz instead
    assign sel_x = kink1_reg ? mg1_reg : ma1_reg;
    assign pa1   = (a1_reg > 0) ? ma1_reg : '0;
    assign pb1   = (b1_reg > 0) ? mb1_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            a1_reg     <= a_value;
            b1_reg     <= b_value;
            ma1_reg    <= mag(a_value);
            mb1_reg    <= mag(b_value);
            mg1_reg    <= mag(kink_gradient);
            gzneg1_reg <= kink_gradient[DATA_W-1];
            kink1_reg  <= (a_value == '0) && (b_value == '0);

            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            ma2_reg    <= ma1_reg;
            mb2_reg    <= mb1_reg;
            mg2_reg    <= mg1_reg;
            gzneg2_reg <= gzneg1_reg;
            kink2_reg  <= kink1_reg;
            sqx_reg    <= sel_x * sel_x;
            sqb_reg    <= mb1_reg * mb1_reg;
            ab_reg     <= ma1_reg * mb1_reg;
            pp_reg     <= pa1 * pb1;
        end
    end

    always_comb
    begin
        push_item.rad = sqx_reg + sqb_reg
                      + (kink2_reg ? (RAD_W'(1) << (2 * FRAC_BITS)) : '0);
        push_item.side.num1 = kink2_reg ? (NUM_W'(1) << (2 * FRAC_BITS))
                                        : (NUM_W'(ma2_reg) << FRAC_BITS);
        push_item.side.num2 = kink2_reg ? (NUM_W'(mg2_reg) << FRAC_BITS)
                                        : (NUM_W'(mb2_reg) << FRAC_BITS);
        push_item.side.neg1     = a2_reg[DATA_W-1];
        push_item.side.neg2     = kink2_reg ? gzneg2_reg : b2_reg[DATA_W-1];
        push_item.side.kink     = kink2_reg;
        push_item.side.sum      = (DATA_W+1)'(a2_reg) + (DATA_W+1)'(b2_reg);
        push_item.side.ab2      = ab_reg << 1;
        push_item.side.phi_neg  = a2_reg[DATA_W-1] != b2_reg[DATA_W-1];
        push_item.side.penq     = PENQ_W'(pp_reg >> FRAC_BITS);
        push_item.side.a        = a2_reg;
        push_item.side.b        = b2_reg;
        push_item.side.pos_both = (a2_reg > 0) && (b2_reg > 0);
    end

endmodule

@@ hdl/fbe_queue.sv @@
module fbe_queue import fbe_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fbe_item_t push_item,
    output logic      full,
    input  logic      pop,
    output fbe_item_t pop_item,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbe_item_t        item_mem [0:DEPTH-1];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_item = item_mem[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wrap_inc(wptr_reg);
            end
            if (pop)
            begin
                rptr_reg <= wrap_inc(rptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/fbe_back.sv @@
module fbe_back import fbe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LAM_W-1:0]  blend,
    output logic              pop,
    input  fbe_item_t         pop_item,
    input  logic              empty,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] fb_value,
    output logic [DATA_W-1:0] deriv_a,
    output logic [DATA_W-1:0] deriv_b,
    output logic              at_kink,
    output logic              clipped
);

    localparam int SQ_SIDE_W = $bits(fbe_sq_side_t);
    localparam int DV_SIDE_W = $bits(fbe_dv_side_t);
    localparam logic signed [PHI_W-1:0] ONE_FIX = PHI_W'(1) <<< FRAC_BITS;

    logic en;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_bits;
    fbe_sq_side_t         sq_side;

    logic signed [PHI_W-1:0] den_wide, small_wide;
    fbe_dv_side_t            dv_in;

    logic                 dvp_valid, dv1_valid, dv2_valid;
    logic [QUOT_W-1:0]    qphi, q1, q2;
    logic [DV_SIDE_W-1:0] dv_side_bits;
    fbe_dv_side_t         dv_side;
    logic                 neg1_o, neg2_o;

    logic [LAM_W-1:0]        lam, cw;
    logic signed [LAM_W:0]   lam_s, c_s;
    logic signed [PHI_W-1:0] q1e, q2e, qpe, d1, d2, phi;

    logic                 va_reg, ka_reg, pba_reg;
    logic signed [52:0]   m_lamphi_reg, m_t1_reg, m_t2_reg;
    logic signed [34:0]   m_clo_reg;
    logic signed [48:0]   m_chi_reg;
    logic signed [49:0]   m_cb_reg, m_ca_reg;

    logic signed [ACC_W-1:0] acc_v, acc_a, acc_b, part_v;
    fbe_sat_t                sat_v, sat_a, sat_b;

    logic              ov_reg, kink_out_reg, clip_reg;
    logic [DATA_W-1:0] fb_reg, da_reg, db_reg;

    // Whole back pipe advances together; the output register is its last stage
    assign en  = !ov_reg || out_ready;
    assign pop = en && !empty;

    fbe_sqrt #(
        .RAD_BITS (RAD_W),
        .SIDE_W   (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!empty),
        .in_rad    (pop_item.rad),
        .in_side   (pop_item.side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_bits)
    );

    assign sq_side    = sq_side_bits;
    assign den_wide   = PHI_W'(sq_side.sum) + PHI_W'({1'b0, sq_root});
    assign small_wide = PHI_W'(sq_side.sum) - PHI_W'({1'b0, sq_root});

    always_comb
    begin
        dv_in.kink      = sq_side.kink;
        dv_in.sum_pos   = sq_side.sum > 0;
        dv_in.phi_neg   = sq_side.phi_neg;
        dv_in.phi_small = small_wide;
        dv_in.penq      = sq_side.penq;
        dv_in.a         = sq_side.a;
        dv_in.b         = sq_side.b;
        dv_in.pos_both  = sq_side.pos_both;
    end

    fbe_div #(
        .N_W    (PHI_NUM_W),
        .D_W    (PHI_DEN_W),
        .Q_W    (QUOT_W),
        .SIDE_W (DV_SIDE_W)
    ) u_div_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side.ab2),
        .in_den    (den_wide[PHI_DEN_W-1:0]),
        .in_side   (dv_in),
        .out_valid (dvp_valid),
        .out_quot  (qphi),
        .out_side  (dv_side_bits)
    );

    fbe_div #(
        .N_W    (NUM_W),
        .D_W    (ROOT_W),
        .Q_W    (QUOT_W),
        .SIDE_W (1)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side.num1),
        .in_den    (sq_root),
        .in_side   (sq_side.neg1),
        .out_valid (dv1_valid),
        .out_quot  (q1),
        .out_side  (neg1_o)
    );

    fbe_div #(
        .N_W    (NUM_W),
        .D_W    (ROOT_W),
        .Q_W    (QUOT_W),
        .SIDE_W (1)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side.num2),
        .in_den    (sq_root),
        .in_side   (sq_side.neg2),
        .out_valid (dv2_valid),
        .out_quot  (q2),
        .out_side  (neg2_o)
    );

    assign dv_side = dv_side_bits;

    assign lam   = (blend > LAM_ONE) ? LAM_ONE : blend;
    assign cw    = LAM_ONE - lam;
    assign lam_s = signed'({1'b0, lam});
    assign c_s   = signed'({1'b0, cw});

    assign q1e = signed'({2'b00, q1});
    assign q2e = signed'({2'b00, q2});
    assign qpe = signed'({2'b00, qphi});
    assign d1  = neg1_o ? ONE_FIX + q1e : ONE_FIX - q1e;
    assign d2  = neg2_o ? ONE_FIX + q2e : ONE_FIX - q2e;
    assign phi = dv_side.sum_pos ? (dv_side.phi_neg ? -qpe : qpe) : dv_side.phi_small;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= dvp_valid && dv1_valid && dv2_valid;
            ov_reg <= va_reg;
        end
    end

    // Exact products, one multiply deep
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ka_reg       <= dv_side.kink;
            pba_reg      <= dv_side.pos_both;
            m_lamphi_reg <= lam_s * phi;
            m_clo_reg    <= c_s * signed'({1'b0, dv_side.penq[15:0]});
            m_chi_reg    <= c_s * signed'({1'b0, dv_side.penq[PENQ_W-1:16]});
            m_t1_reg     <= lam_s * d1;
            m_t2_reg     <= lam_s * d2;
            m_cb_reg     <= c_s * dv_side.b;
            m_ca_reg     <= c_s * dv_side.a;
        end
    end

    // Keep every operand signed so the shifts floor
    always_comb
    begin
        part_v = ACC_W'(m_lamphi_reg) + ACC_W'(m_clo_reg);
        acc_v  = ka_reg ? ACC_W'(0) : ACC_W'(m_chi_reg) + (part_v >>> FRAC_BITS);
        acc_a  = (ACC_W'(m_t1_reg) + (pba_reg ? ACC_W'(m_cb_reg) : ACC_W'(0)))
                 >>> FRAC_BITS;
        acc_b  = (ACC_W'(m_t2_reg) + (pba_reg ? ACC_W'(m_ca_reg) : ACC_W'(0)))
                 >>> FRAC_BITS;
        sat_v  = saturate(acc_v);
        sat_a  = saturate(acc_a);
        sat_b  = saturate(acc_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fb_reg       <= sat_v.val;
            da_reg       <= sat_a.val;
            db_reg       <= sat_b.val;
            kink_out_reg <= ka_reg;
            clip_reg     <= sat_v.clip || sat_a.clip || sat_b.clip;
        end
    end

    assign out_valid = ov_reg;
    assign fb_value  = fb_reg;
    assign deriv_a   = da_reg;
    assign deriv_b   = db_reg;
    assign at_kink   = kink_out_reg;
    assign clipped   = clip_reg;

endmodule

@@ hdl/fischer_burmeister_ncp_eval.sv @@
// 72 register stages from input transfer to result valid, counting the one that takes
// the transfer: 2 front, 1 queue, 33 square-root, 34 divider, 2 combine.
// Throughput: one pair per cycle when not stalled; set by the one-bit-per-stage root and divider pipes.
// A result not taken stalls the back pipe; the queue keeps taking input until full.
// Reset (rst_n low, asynchronous) empties all pipes and the queue and sets
// blend_reg to 1.0.
module fischer_burmeister_ncp_eval import fbe_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [LAM_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] a_value,
    input  logic signed [DATA_W-1:0] b_value,
    input  logic signed [DATA_W-1:0] kink_gradient,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] fb_value,
    output logic signed [DATA_W-1:0] deriv_a,
    output logic signed [DATA_W-1:0] deriv_b,
    output logic                     at_kink,
    output logic                     clipped
);

    logic [LAM_W-1:0] blend_reg;
    logic             push, full, pop, empty;
    fbe_item_t        push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= LAM_ONE;
        end
        else if (cfg_wr_en)
        begin
            blend_reg <= cfg_wr_data;
        end
    end

    fbe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .a_value       (a_value),
        .b_value       (b_value),
        .kink_gradient (kink_gradient),
        .push          (push),
        .push_item     (push_item),
        .full          (full)
    );

    fbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    fbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .blend     (blend_reg),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fb_value  (fb_value),
        .deriv_a   (deriv_a),
        .deriv_b   (deriv_b),
        .at_kink   (at_kink),
        .clipped   (clipped)
    );

endmodule

@@ hdl/fbe_checker.sv @@
module fbe_checker import fbe_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] fb_value,
    input logic [DATA_W-1:0] deriv_a,
    input logic              at_kink,
    input logic              clipped
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fb_value) && $stable(deriv_a))
        else $error("stalled result changed");

    a_kink_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_kink |-> fb_value == '0)
        else $error("kink result with nonzero value");

    a_kink_noclip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_kink |-> !clipped)
        else $error("kink result flagged as saturated");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind fischer_burmeister_ncp_eval fbe_checker u_fbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fb_value  (fb_value),
    .deriv_a   (deriv_a),
    .at_kink   (at_kink),
    .clipped   (clipped)
);
